### rtl/owr_pkg.sv
// ----------------------------------------------------------------------------
// owr_pkg
// Types, codes and the CRC-8 helper shared by the 1-Wire search ROM engine.
// ----------------------------------------------------------------------------
package owr_pkg;

	localparam int ROM_W   = 64;
	localparam int POS_W   = 7;
	localparam int IDX_W   = 6;
	localparam int CRC_W   = 8;
	localparam int CMD_W   = 8;
	localparam int STAT_W  = 3;

	localparam logic [CMD_W-1:0] CMD_SEARCH = 8'hF0;
	localparam logic [CMD_W-1:0] CMD_ALARM  = 8'hEC;
	localparam logic [CRC_W-1:0] CRC_POLY   = 8'h8C;
	localparam logic [POS_W-1:0] POS_FIRST  = 7'd1;
	localparam logic [POS_W-1:0] POS_FINAL  = 7'd65;

	// request kinds
	localparam logic REQ_BEGIN = 1'b0;
	localparam logic REQ_BIT   = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_BIT    = 3'd0,
		ST_START  = 3'd1,
		ST_FOUND  = 3'd2,
		ST_FAIL   = 3'd3,
		ST_NOMORE = 3'd4,
		ST_NOPRES = 3'd5
	} status_t;

	typedef struct packed {
		logic req_type;
		logic first_search;
		logic do_reset;
		logic presence;
		logic alarm_only;
		logic id_bit;
		logic cmp_bit;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [CMD_W-1:0]  command_byte;
		logic              write_valid;
		logic              write_bit;
		logic [ROM_W-1:0]  rom_code;
		logic              last_device;
	} rsp_t;

	// Dallas/Maxim CRC-8, reflected, LSB first
	function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc_in,
	                                               input logic [7:0] data_in);
		logic [CRC_W-1:0] c;
		logic [7:0]       d;
		logic             mix;
		c = crc_in;
		d = data_in;
		for (int k = 0; k < 8; k++) begin
			mix = c[0] ^ d[0];
			c   = c >> 1;
			if (mix) begin
				c = c ^ CRC_POLY;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

### rtl/owr_if.sv
// ----------------------------------------------------------------------------
// owr_req_if / owr_rsp_if
// Valid/ready channels for search requests and their results.
// ----------------------------------------------------------------------------
interface owr_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic first_search;
	logic do_reset;
	logic presence;
	logic alarm_only;
	logic id_bit;
	logic cmp_bit;

	modport source (output valid, output req_type, output first_search, output do_reset,
		output presence, output alarm_only, output id_bit, output cmp_bit, input ready);
	modport sink (input valid, input req_type, input first_search, input do_reset,
		input presence, input alarm_only, input id_bit, input cmp_bit, output ready);
endinterface

interface owr_rsp_if import owr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [CMD_W-1:0]  command_byte;
	logic              write_valid;
	logic              write_bit;
	logic [ROM_W-1:0]  rom_code;
	logic              last_device;

	modport source (output valid, output status, output command_byte, output write_valid,
		output write_bit, output rom_code, output last_device, input ready);
	modport sink (input valid, input status, input command_byte, input write_valid,
		input write_bit, input rom_code, input last_device, output ready);
endinterface

### rtl/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search
// 1-Wire search ROM engine: begin/bit requests in, command, direction bit,
// ROM code and search status out.
// ----------------------------------------------------------------------------
//  channel  role  handshake     payload
//  req      sink  valid/ready   req_type first_search do_reset presence
//                               alarm_only id_bit cmp_bit
//  rsp      src   valid/ready   status command_byte write_valid write_bit
//                               rom_code last_device
//
//  One request per cycle sustained while rsp.ready holds; a request passes
//  through the input register, then the result register, where its result
//  is valid and can be accepted.
//  All search work for a request is done combinationally in owr_core.
//  arst_n clears the search state: bit position 1, no pass open.
//  A stalled result holds in the result register; one more request can
//  wait in the input register, then req.ready drops.
// ----------------------------------------------------------------------------
module onewire_rom_search import owr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	owr_req_if.sink   req,
	owr_rsp_if.source rsp
);

	req_t item_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	rsp_t step_rsp;
	logic advance;

	// move the input item forward when the result slot is free or draining
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type     <= req.req_type;
			item_s1.first_search <= req.first_search;
			item_s1.do_reset     <= req.do_reset;
			item_s1.presence     <= req.presence;
			item_s1.alarm_only   <= req.alarm_only;
			item_s1.id_bit       <= req.id_bit;
			item_s1.cmp_bit      <= req.cmp_bit;
		end
	end

	// search state lives in the core and steps with each advancing item
	owr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.result  (step_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= step_rsp;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.status       = rsp_s2.status;
	assign rsp.command_byte = rsp_s2.command_byte;
	assign rsp.write_valid  = rsp_s2.write_valid;
	assign rsp.write_bit    = rsp_s2.write_bit;
	assign rsp.rom_code     = rsp_s2.rom_code;
	assign rsp.last_device  = rsp_s2.last_device;

	// a command byte only comes with a started pass
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.command_byte != '0 |-> rsp_s2.status == ST_START)
		else $error("command byte without pass start");

	// direction bit comes only with bit, found or failed results
	a_wbit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.write_valid |-> (rsp_s2.status == ST_BIT
			|| rsp_s2.status == ST_FOUND || rsp_s2.status == ST_FAIL))
		else $error("write bit with wrong status");

	// the input stage never drops an item that has not moved on
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input item lost");

endmodule

### rtl/owr_core.sv
// ----------------------------------------------------------------------------
// owr_core
// Search state and the combinational step logic for one request.
// ----------------------------------------------------------------------------
module owr_core import owr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  req_t item,
	output rsp_t result
);

	logic [ROM_W-1:0] rom_q, rom_n;
	logic [POS_W-1:0] ld_q, ld_n;        // last discrepancy
	logic             ldf_q, ldf_n;      // last device flag
	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] mark_q, mark_n;    // discrepancy marker
	logic [CRC_W-1:0] crc_q, crc_n;
	logic             act_q, act_n;

	logic [IDX_W-1:0] idx;
	logic [POS_W-1:0] pos_inc;
	logic             dir;
	logic [ROM_W-1:0] rom_set;
	logic [7:0]       byte_sel;
	logic [CRC_W-1:0] crc_upd;

	assign idx     = pos_q[IDX_W-1:0] - 6'd1;
	assign pos_inc = pos_q + 7'd1;

	// direction choice for a bit pair
	always_comb begin
		if (item.id_bit || item.cmp_bit) begin
			dir = item.id_bit;
		end else if (pos_q < ld_q) begin
			dir = rom_q[idx];
		end else begin
			dir = (pos_q == ld_q);
		end
	end

	always_comb begin
		rom_set      = rom_q;
		rom_set[idx] = dir;
	end

	assign byte_sel = rom_set[{idx[5:3], 3'b000} +: 8];
	assign crc_upd  = (idx[2:0] == 3'd7) ? crc8_byte(crc_q, byte_sel) : crc_q;

	always_comb begin
		rom_n  = rom_q;
		ld_n   = ld_q;
		ldf_n  = ldf_q;
		pos_n  = pos_q;
		mark_n = mark_q;
		crc_n  = crc_q;
		act_n  = act_q;
		result = '0;
		result.status = ST_BIT;

		if (item.req_type == REQ_BEGIN) begin
			act_n = 1'b0;
			if (item.first_search) begin
				ld_n  = '0;
				ldf_n = 1'b0;
			end
			if (ldf_n) begin
				ld_n  = '0;
				ldf_n = 1'b0;
				result.status = ST_NOMORE;
			end else if (item.do_reset && !item.presence) begin
				ld_n = '0;
				result.status = ST_NOPRES;
			end else begin
				result.status       = ST_START;
				result.command_byte = item.alarm_only ? CMD_ALARM : CMD_SEARCH;
				act_n  = 1'b1;
				pos_n  = POS_FIRST;
				mark_n = '0;
				crc_n  = '0;
			end
		end else if (act_q) begin
			if (item.id_bit && item.cmp_bit) begin
				ld_n  = '0;
				act_n = 1'b0;
				result.status = ST_FAIL;
			end else begin
				if (!item.id_bit && !item.cmp_bit && !dir) begin
					mark_n = pos_q;
				end
				rom_n = rom_set;
				crc_n = crc_upd;
				pos_n = pos_inc;
				result.write_valid = 1'b1;
				result.write_bit   = dir;
				if (pos_inc >= POS_FINAL) begin
					act_n = 1'b0;
					if (crc_upd == '0) begin
						ld_n  = mark_n;
						ldf_n = (mark_n == '0);
						result.status = ST_FOUND;
					end else begin
						ld_n = '0;
						result.status = ST_FAIL;
					end
				end
			end
		end

		result.rom_code    = rom_n;
		result.last_device = ldf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q  <= '0;
			ld_q   <= '0;
			ldf_q  <= 1'b0;
			pos_q  <= POS_FIRST;
			mark_q <= '0;
			crc_q  <= '0;
			act_q  <= 1'b0;
		end else if (step_en) begin
			rom_q  <= rom_n;
			ld_q   <= ld_n;
			ldf_q  <= ldf_n;
			pos_q  <= pos_n;
			mark_q <= mark_n;
			crc_q  <= crc_n;
			act_q  <= act_n;
		end
	end

	// an open pass always sits on a real bit slot
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (pos_q >= POS_FIRST && pos_q < POS_FINAL))
		else $error("bit position out of range during pass");

	// state moves only on a step
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(rom_q) && $stable(ld_q) && $stable(act_q) && $stable(ldf_q))
		else $error("search state changed without a step");

	// a found device records its marker as the next start point
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.status == ST_FOUND |=> ld_q == $past(mark_n) && !act_q
			&& ldf_q == (ld_q == '0))
		else $error("found pass did not save discrepancy");

	// bit direction is only given on bit steps of an open pass
	a_wv: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.write_valid |-> act_q && item.req_type == REQ_BIT)
		else $error("write bit outside an open pass");

endmodule
